>>> rtl/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// shared types and constants of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package plti_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_WIDTH  = 32;
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int DIV_STEPS   = DATA_WIDTH;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_INSERT  = 2'd1,
      OP_CONVERT = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // breakpoint handed from one cell to the next
   typedef struct packed {
      logic [DATA_WIDTH-1:0] key;
      logic [DATA_WIDTH-1:0] value;
   } cell_tap_type;

   // broadcast to every cell
   typedef struct packed {
      logic                  shift_en;
      logic                  replace_en;
      logic [DATA_WIDTH-1:0] key;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage

>>> rtl/piecewise_linear_table_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_core
// sorted breakpoint table with linear interpolation between neighbors
// ----------------------------------------------------------------------------
// Issue a beat by raising start while busy is low; the beat is taken at that
// edge and busy stays high until its result has been launched. Every beat
// gives exactly one result, shown for a single cycle with rsp_valid high; the
// receiver cannot stall it, so sample it in that cycle. Clear, insert, unused
// opcodes and converts on an empty table, at or below the first key or past the
// last key pass through the table search and then show the result. A convert
// that interpolates, an exact hit on an inner or on the last key included,
// runs the table search, a multiply, the restoring divider (one quotient bit
// per cycle) and a round and saturate step before the result is shown.
// Breakpoints live in a chain of 16 cells kept sorted by key; an insert
// shifts the upper cells up by one during the table search.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_core import plti_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_cmd_or_key,
   input  logic signed [DATA_WIDTH-1:0] req_point_value,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                   rsp_status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   opcode_type            op_ff;
   opcode_type            op_in;
   logic [DATA_WIDTH-1:0] cmd_ff;
   logic [DATA_WIDTH-1:0] cmd_in;
   logic [DATA_WIDTH-1:0] pval_ff;
   logic [DATA_WIDTH-1:0] pval_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   // interpolation operands
   logic [DATA_WIDTH-1:0] mag_ff;
   logic [DATA_WIDTH-1:0] mag_in;
   logic [DATA_WIDTH-1:0] w1_ff;
   logic [DATA_WIDTH-1:0] w1_in;
   logic [DATA_WIDTH-1:0] span_ff;
   logic [DATA_WIDTH-1:0] span_in;
   logic [DATA_WIDTH-1:0] o0_ff;
   logic [DATA_WIDTH-1:0] o0_in;
   logic                  neg_ff;
   logic                  neg_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [DATA_WIDTH-1:0] rsp_value_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;

   // cell chain
   cell_ctrl_type         cell_ctrl;
   logic [TABLE_DEPTH-1:0] entry_valid;
   logic [TABLE_DEPTH-1:0] above;
   logic [TABLE_DEPTH-1:0] prev_above;
   logic [TABLE_DEPTH-1:0] match;
   cell_tap_type          tap [TABLE_DEPTH];
   cell_tap_type          prev_tap [TABLE_DEPTH];

   logic                  any_match;
   logic                  any_ge;
   logic                  table_full;
   cell_tap_type          hi_tap;
   cell_tap_type          lo_tap;
   logic [DATA_WIDTH:0]   span_w;
   logic [DATA_WIDTH:0]   w1_w;
   logic [DATA_WIDTH:0]   diff_w;
   logic [DATA_WIDTH:0]   mag_w;

   // divider
   logic                  div_load;
   logic [PROD_WIDTH-1:0] product;
   logic                  div_done;
   logic [DATA_WIDTH-1:0] quotient;
   logic                  rem_nonzero;

   // rounding and saturation
   logic signed [DATA_WIDTH+1:0] sum_w;
   logic signed [DATA_WIDTH+1:0] adj_w;
   logic [DATA_WIDTH-1:0]        final_value;

   localparam logic signed [DATA_WIDTH+1:0] SAT_MAX = {3'b000, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [DATA_WIDTH+1:0] SAT_MIN = {3'b111, {(DATA_WIDTH - 1){1'b0}}};

   // ---- chain of breakpoint cells ----
   assign cell_ctrl.shift_en   = state_ff == ST_SCAN && op_ff == OP_INSERT
                                 && !any_match && !table_full;
   assign cell_ctrl.replace_en = state_ff == ST_SCAN && op_ff == OP_INSERT;
   assign cell_ctrl.key        = cmd_ff;
   assign cell_ctrl.value      = pval_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign entry_valid[i] = count_ff > COUNT_WIDTH'(i);
      if (i == 0) begin : g_first
         assign prev_above[i] = 1'b0;
         assign prev_tap[i]   = '{key: cmd_ff, value: pval_ff};
      end else begin : g_rest
         assign prev_above[i] = above[i-1];
         assign prev_tap[i]   = tap[i-1];
      end
      plti_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .entry_valid(entry_valid[i]),
         .prev_above (prev_above[i]),
         .prev_tap   (prev_tap[i]),
         .above      (above[i]),
         .match      (match[i]),
         .tap        (tap[i])
      );
   end

   assign any_match  = |match;
   assign any_ge     = |(above & entry_valid);
   assign table_full = count_ff == COUNT_WIDTH'(TABLE_DEPTH);

   // hi: first entry at or above the command, lo: the one just below it
   always_comb begin
      hi_tap = '0;
      lo_tap = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (above[i] && !prev_above[i]) begin
            hi_tap = hi_tap | tap[i];
         end
         if (!above[i] && (i == TABLE_DEPTH - 1 || above[(i + 1) % TABLE_DEPTH])) begin
            lo_tap = lo_tap | tap[i];
         end
      end
   end

   always_comb begin
      span_w = {hi_tap.key[DATA_WIDTH-1], hi_tap.key} - {lo_tap.key[DATA_WIDTH-1], lo_tap.key};
      w1_w   = {cmd_ff[DATA_WIDTH-1], cmd_ff} - {lo_tap.key[DATA_WIDTH-1], lo_tap.key};
      diff_w = {hi_tap.value[DATA_WIDTH-1], hi_tap.value}
               - {lo_tap.value[DATA_WIDTH-1], lo_tap.value};
      mag_w  = diff_w[DATA_WIDTH] ? ((DATA_WIDTH + 1)'(0) - diff_w) : diff_w;
   end

   // ---- multiply and divide ----
   assign div_load = state_ff == ST_MUL;
   assign product  = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(w1_ff);

   plti_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .load       (div_load),
      .dividend   (product),
      .divisor    (span_ff),
      .done       (div_done),
      .quotient   (quotient),
      .rem_nonzero(rem_nonzero)
   );

   // o0 plus or minus the quotient, truncated toward zero, then clamped
   always_comb begin
      if (neg_ff) begin
         sum_w = (DATA_WIDTH + 2)'($signed(o0_ff)) - $signed({2'b00, quotient});
      end else begin
         sum_w = (DATA_WIDTH + 2)'($signed(o0_ff)) + $signed({2'b00, quotient});
      end
      adj_w = sum_w;
      if (rem_nonzero) begin
         if (!neg_ff && sum_w < 0) begin
            adj_w = sum_w + 1;
         end else if (neg_ff && sum_w > 0) begin
            adj_w = sum_w - 1;
         end
      end
      if (adj_w > SAT_MAX) begin
         final_value = SAT_MAX[DATA_WIDTH-1:0];
      end else if (adj_w < SAT_MIN) begin
         final_value = SAT_MIN[DATA_WIDTH-1:0];
      end else begin
         final_value = adj_w[DATA_WIDTH-1:0];
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd_in        = cmd_ff;
      pval_in       = pval_ff;
      count_in      = count_ff;
      mag_in        = mag_ff;
      w1_in         = w1_ff;
      span_in       = span_ff;
      o0_in         = o0_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = opcode_type'(req_opcode);
               cmd_in   = req_cmd_or_key;
               pval_in  = req_point_value;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // default: answer right away with a zero value
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = STATUS_OK;
            unique case (op_ff)
               OP_CLEAR: begin
                  count_in = '0;
               end
               OP_INSERT: begin
                  if (!any_match) begin
                     if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               OP_CONVERT: begin
                  if (count_ff == '0) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else if (!any_ge) begin
                     // past the last key
                     rsp_value_in = lo_tap.value;
                  end else if (above[0]) begin
                     // at or below the first key
                     rsp_value_in = hi_tap.value;
                  end else begin
                     span_in      = span_w[DATA_WIDTH-1:0];
                     w1_in        = w1_w[DATA_WIDTH-1:0];
                     mag_in       = mag_w[DATA_WIDTH-1:0];
                     neg_in       = diff_w[DATA_WIDTH];
                     o0_in        = lo_tap.value;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_MUL;
                  end
               end
               OP_UNUSED: begin
               end
            endcase
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = final_value;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      cmd_ff        <= cmd_in;
      pval_ff       <= pval_in;
      mag_ff        <= mag_in;
      w1_ff         <= w1_in;
      span_ff       <= span_in;
      o0_ff         <= o0_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> rtl/plti_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_cell
// one breakpoint slot of the sorted chain: compares, shifts up, replaces
// ----------------------------------------------------------------------------
module plti_cell import plti_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          entry_valid,
   input  logic          prev_above,
   input  cell_tap_type  prev_tap,
   output logic          above,
   output logic          match,
   output cell_tap_type  tap
);

   cell_tap_type entry_ff;
   cell_tap_type entry_in;

   // an empty slot counts as above every key
   always_comb begin
      above = !entry_valid || ($signed(entry_ff.key) >= $signed(ctrl.key));
      match = entry_valid && (entry_ff.key == ctrl.key);
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_en) begin
         if (prev_above) begin
            entry_in = prev_tap;
         end else if (above) begin
            entry_in.key   = ctrl.key;
            entry_in.value = ctrl.value;
         end
      end else if (ctrl.replace_en && match) begin
         entry_in.value = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tap = entry_ff;

endmodule

>>> rtl/plti_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_divider
// restoring divider, one quotient bit per cycle, 64 by 32 bits
// ----------------------------------------------------------------------------
module plti_divider import plti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [PROD_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic                  rem_nonzero
);

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] quo_in;
   logic [DATA_WIDTH-1:0] dsr_ff;
   logic [DATA_WIDTH-1:0] dsr_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   // upper half of the dividend is below the divisor, so 32 steps suffice
   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (load) begin
         step_in = STEP_WIDTH'(DIV_STEPS);
         rem_in  = dividend[PROD_WIDTH-1:DATA_WIDTH];
         quo_in  = dividend[DATA_WIDTH-1:0];
         dsr_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done        = (step_ff == '0);
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

>>> rtl/plti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_checker
// port level checks of the interpolator core, bound to the top level
// ----------------------------------------------------------------------------
module plti_checker import plti_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [DATA_WIDTH-1:0] rsp_result_value,
   input logic [1:0]            rsp_status
);

   // a taken beat makes the core busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("core not busy after a taken beat");

   // a result only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a beat in progress");

   // busy drops exactly when the result goes out
   a_busy_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // result strobe never overlaps busy
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // any error status carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_result_value == '0)
      else $error("error result with nonzero value");

endmodule

bind piecewise_linear_table_interpolator_core plti_checker u_plti_checker (.*);
